/* sv/fdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdf_pkg: shared types and constants for the frame datagram fragmenter
// Payload size per datagram, field widths and header flag codes.
// ----------------------------------------------------------------------------
package fdf_pkg;

  // Largest payload carried by one datagram (1 .. 65536)
  localparam int unsigned PAYLOAD_BYTES = 1024;

  localparam int unsigned SIZE_W  = 24;
  localparam int unsigned CHUNK_W = 16;
  localparam int unsigned BYTE_W  = 8;

  typedef logic [SIZE_W-1:0]  size_t;
  typedef logic [CHUNK_W-1:0] chunk_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  // Input action codes
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_DATA  = 1'b1;

  // Header flag byte values
  localparam byte_t FLAG_LAST = 8'h01;
  localparam byte_t FLAG_MORE = 8'h00;

  // One accepted data byte with everything needed to emit its beats
  typedef struct packed {
    logic  hdr;       // byte opens a datagram: header goes first
    logic  last_dgm;  // datagram ends the frame
    size_t offset;    // frame offset of this byte
    byte_t data;      // payload byte
    logic  dgm_end;   // byte closes its datagram
  } item_t;

endpackage

/* sv/frame_datagram_fragmenter_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_datagram_fragmenter_unit: cut a frame byte stream into datagrams
// Frame-start beats declare a size; data beats are emitted as payload with a
// 4-byte header (flag, 24-bit offset MSB first) opening each datagram.
// ----------------------------------------------------------------------------
// A data beat normally gives one output beat; a data beat that opens a
// datagram gives five output beats (four header bytes and the payload byte),
// so a following beat can be stalled while the header goes out, once per
// datagram. Frame-start beats and bytes past the declared size produce no
// output and never occupy the input register, but like any beat they wait
// while in_stall is high. The output sequencer sends one byte per cycle
// while out_stall is low; a one-entry input register ahead of it holds one
// more data beat while the sequencer's beat waits on out_stall.
module frame_datagram_fragmenter_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_action,
  input  fdf_pkg::size_t in_frame_size,
  input  fdf_pkg::byte_t in_data_byte,
  output logic           out_valid,
  input  logic           out_stall,
  output fdf_pkg::byte_t out_out_byte,
  output logic           out_datagram_start,
  output logic           out_datagram_end,
  output logic           out_run_last
);
  import fdf_pkg::*;

  typedef enum logic [2:0] {
    BEAT_FLAG,
    BEAT_OFF_HI,
    BEAT_OFF_MID,
    BEAT_OFF_LO,
    BEAT_DATA
  } beat_t;

  localparam size_t  PAYLOAD_SZ  = size_t'(PAYLOAD_BYTES);
  localparam logic [CHUNK_W:0] PAYLOAD_CK = (CHUNK_W+1)'(PAYLOAD_BYTES);

  // Frame tracking state
  size_t  declared_size_r, declared_size_nxt;
  size_t  byte_offset_r,   byte_offset_nxt;
  chunk_t chunk_pos_r,     chunk_pos_nxt;

  // Input register and output sequencer
  logic  a_valid_r, a_valid_nxt;
  item_t a_item_r,  a_item_nxt;
  logic  b_valid_r, b_valid_nxt;
  item_t b_item_r,  b_item_nxt;
  beat_t beat_r,    beat_nxt;

  logic             in_acc, out_acc, b_done, a_move, a_load;
  logic             active;
  size_t            remaining;
  logic [CHUNK_W:0] chunk_inc;
  logic             byte_end;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign b_done  = out_acc && (beat_r == BEAT_DATA);
  assign a_move  = a_valid_r && (!b_valid_r || b_done);
  assign in_stall = a_valid_r && !a_move;

  // Classify the incoming data beat against the open frame
  assign active    = byte_offset_r < declared_size_r;
  assign remaining = declared_size_r - byte_offset_r;
  assign chunk_inc = {1'b0, chunk_pos_r} + (CHUNK_W+1)'(1);
  assign byte_end  = (remaining == size_t'(1)) || (chunk_inc >= PAYLOAD_CK);
  assign a_load    = in_acc && (in_action == ACT_DATA) && active;

  always_comb begin
    declared_size_nxt = declared_size_r;
    byte_offset_nxt   = byte_offset_r;
    chunk_pos_nxt     = chunk_pos_r;
    a_item_nxt        = a_item_r;
    if (in_acc && in_action == ACT_START) begin
      declared_size_nxt = in_frame_size;
      byte_offset_nxt   = '0;
      chunk_pos_nxt     = '0;
    end else if (a_load) begin
      a_item_nxt.hdr      = (chunk_pos_r == '0);
      a_item_nxt.last_dgm = (remaining <= PAYLOAD_SZ);
      a_item_nxt.offset   = byte_offset_r;
      a_item_nxt.data     = in_data_byte;
      a_item_nxt.dgm_end  = byte_end;
      byte_offset_nxt     = byte_offset_r + size_t'(1);
      chunk_pos_nxt       = byte_end ? '0 : chunk_inc[CHUNK_W-1:0];
    end
  end

  // Hold or hand over the input register
  always_comb begin
    a_valid_nxt = a_valid_r;
    if (a_load) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end
  end

  // Advance the output sequencer one byte per accepted beat
  always_comb begin
    b_valid_nxt = b_valid_r;
    b_item_nxt  = b_item_r;
    beat_nxt    = beat_r;
    if (a_move) begin
      b_valid_nxt = 1'b1;
      b_item_nxt  = a_item_r;
      beat_nxt    = a_item_r.hdr ? BEAT_FLAG : BEAT_DATA;
    end else if (b_done) begin
      b_valid_nxt = 1'b0;
    end else if (out_acc) begin
      unique case (beat_r)
        BEAT_FLAG:    beat_nxt = BEAT_OFF_HI;
        BEAT_OFF_HI:  beat_nxt = BEAT_OFF_MID;
        BEAT_OFF_MID: beat_nxt = BEAT_OFF_LO;
        BEAT_OFF_LO:  beat_nxt = BEAT_DATA;
        default:      beat_nxt = BEAT_DATA;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      declared_size_r <= '0;
      byte_offset_r   <= '0;
      chunk_pos_r     <= '0;
      a_valid_r       <= 1'b0;
      b_valid_r       <= 1'b0;
      beat_r          <= BEAT_DATA;
    end else begin
      declared_size_r <= declared_size_nxt;
      byte_offset_r   <= byte_offset_nxt;
      chunk_pos_r     <= chunk_pos_nxt;
      a_valid_r       <= a_valid_nxt;
      b_valid_r       <= b_valid_nxt;
      beat_r          <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_item_r <= a_item_nxt;
    b_item_r <= b_item_nxt;
  end

  // Drive the output beat
  always_comb begin
    unique case (beat_r)
      BEAT_FLAG:    out_out_byte = b_item_r.last_dgm ? FLAG_LAST : FLAG_MORE;
      BEAT_OFF_HI:  out_out_byte = b_item_r.offset[23:16];
      BEAT_OFF_MID: out_out_byte = b_item_r.offset[15:8];
      BEAT_OFF_LO:  out_out_byte = b_item_r.offset[7:0];
      default:      out_out_byte = b_item_r.data;
    endcase
  end

  assign out_valid          = b_valid_r;
  assign out_datagram_start = (beat_r == BEAT_FLAG);
  assign out_datagram_end   = (beat_r == BEAT_DATA) && b_item_r.dgm_end;
  assign out_run_last       = (beat_r == BEAT_DATA);

  // Checks
  a_offset_bound : assert property (@(posedge clk) disable iff (!rst_n)
    byte_offset_r <= declared_size_r)
    else $error("byte offset passed declared frame size");

  a_hdr_order : assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && beat_r == BEAT_FLAG) |=> (out_valid && beat_r == BEAT_OFF_HI))
    else $error("header flag byte not followed by offset byte");

  a_start_not_last : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_datagram_start |-> !out_run_last)
    else $error("datagram start marked as last result");

  a_stall_only_busy : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (a_valid_r && b_valid_r))
    else $error("input stalled with a free stage");

endmodule
